@@ hdl/paeu_pkg.sv @@
// Package for the pseudo-assembler execute unit: opcodes, sizes, state codes.
// No dependencies.
package paeu_pkg;

    localparam int MemWords  = 256;
    localparam int MemAw     = $clog2(MemWords);
    localparam int ProgLines = 4096;
    localparam int PcW       = $clog2(ProgLines);

    localparam logic [4:0] F_AR = 5'd0;
    localparam logic [4:0] F_SR = 5'd1;
    localparam logic [4:0] F_MR = 5'd2;
    localparam logic [4:0] F_DR = 5'd3;
    localparam logic [4:0] F_CR = 5'd4;
    localparam logic [4:0] F_LR = 5'd5;
    localparam logic [4:0] F_A  = 5'd6;
    localparam logic [4:0] F_S  = 5'd7;
    localparam logic [4:0] F_M  = 5'd8;
    localparam logic [4:0] F_D  = 5'd9;
    localparam logic [4:0] F_C  = 5'd10;
    localparam logic [4:0] F_L  = 5'd11;
    localparam logic [4:0] F_LA = 5'd12;
    localparam logic [4:0] F_ST = 5'd13;
    localparam logic [4:0] F_J  = 5'd14;
    localparam logic [4:0] F_JP = 5'd15;
    localparam logic [4:0] F_JN = 5'd16;
    localparam logic [4:0] F_JZ = 5'd17;

    localparam logic [1:0] ST_ZERO = 2'd0;
    localparam logic [1:0] ST_POS  = 2'd1;
    localparam logic [1:0] ST_NEG  = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_ADDR  = 7'b0000100,
        S_READ  = 7'b0001000,
        S_EXEC  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    function automatic logic [1:0] sign_status(input logic [31:0] v);
        if (v == 32'd0) return ST_ZERO;
        return v[31] ? ST_NEG : ST_POS;
    endfunction

    // signed divide by four, truncating toward zero
    function automatic logic [31:0] quarter(input logic [31:0] v);
        logic [31:0] t;
        t = v + (v[31] ? 32'd3 : 32'd0);
        return {{2{t[31]}}, t[31:2]};
    endfunction

endpackage

@@ hdl/pseudo_assembler_execute_unit.sv @@
// Top level of the pseudo-assembler execute unit: register file, data memory,
// sequencer and a shared bit-serial divider. Depends on paeu_pkg.
//
// channel | dir | fields (tdata, lowest bit first)
// s_axis  | in  | func[4:0] dst_reg[8:5] src_reg[12:9] index_reg[16:13] mem_word[24:17]
//         |     | from_label[25] jump_target[37:26] pc[49:38], zero fill to 56 bits
// m_axis  | out | next_pc[11:0] status[13:12] dst_value[45:14] div_by_zero[46], to 48
//
// The result is offered after the S_ADDR, S_READ and S_EXEC states, and after S_DIV as well for a
// divide by a nonzero divisor, where the bit-serial divider forms the quotient one bit at a time.
// After reset a clearing pass zeroes the data memory word by word before any transfer.
// A new item is taken only once the previous result has been transferred.
module pseudo_assembler_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // func, dst_reg, src_reg, index_reg, mem_word,
                                       // from_label, jump_target, pc
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // next_pc, status, dst_value, div_by_zero
);

    paeu_pkg::t_state r_state, n_state;

    logic [31:0] r_regs [16];
    logic [31:0] r_mem [paeu_pkg::MemWords];
    logic [31:0] r_mrd;
    logic [paeu_pkg::MemAw-1:0] r_clr;
    logic [1:0]  r_status;

    logic [4:0]  r_func;
    logic [3:0]  r_d, r_s, r_x;
    logic [7:0]  r_word;
    logic        r_lab;
    logic [paeu_pkg::PcW-1:0] r_tgt, r_pc, r_npc;
    logic [paeu_pkg::MemAw-1:0] r_addr;
    logic        r_dz;

    // divider
    logic [31:0] r_q, r_rem, r_dvs;
    logic [5:0]  r_cnt;
    logic        r_qneg;
    logic [32:0] w_trial;

    logic [31:0] w_a, w_b, w_sum, w_mul, w_res;
    logic        w_take;
    logic [31:0] w_jq;
    logic [paeu_pkg::PcW-1:0] w_npc;

    assign s_axis_tready = (r_state == paeu_pkg::S_IDLE);
    assign m_axis_tvalid = (r_state == paeu_pkg::S_OUT);
    assign m_axis_tdata  = {1'b0, r_dz, r_regs[r_d], r_status, r_npc};

    assign w_a   = r_regs[r_d];
    assign w_b   = (r_func <= paeu_pkg::F_LR) ? r_regs[r_s] : r_mrd;
    assign w_mul = w_a * w_b;
    assign w_trial = {r_rem[31:0], r_q[31]} - {1'b0, r_dvs};
    assign w_sum = (r_func inside {paeu_pkg::F_AR, paeu_pkg::F_A}) ? w_a + w_b : w_a - w_b;
    assign w_take = (r_func == paeu_pkg::F_J)
        || (r_func == paeu_pkg::F_JP && r_status == paeu_pkg::ST_POS)
        || (r_func == paeu_pkg::F_JN && r_status == paeu_pkg::ST_NEG)
        || (r_func == paeu_pkg::F_JZ && r_status == paeu_pkg::ST_ZERO);
    assign w_res = r_qneg ? -r_q : r_q;
    assign w_jq  = paeu_pkg::quarter(r_regs[15]);
    assign w_npc = w_take ? r_tgt + w_jq[paeu_pkg::PcW-1:0] : r_pc + 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            paeu_pkg::S_CLEAR: if (r_clr == '1) n_state = paeu_pkg::S_IDLE;
            paeu_pkg::S_IDLE:  if (s_axis_tvalid) n_state = paeu_pkg::S_ADDR;
            paeu_pkg::S_ADDR:  n_state = paeu_pkg::S_READ;
            paeu_pkg::S_READ:  n_state = paeu_pkg::S_EXEC;
            paeu_pkg::S_EXEC: begin
                if ((r_func inside {paeu_pkg::F_DR, paeu_pkg::F_D}) && w_b != 32'd0)
                    n_state = paeu_pkg::S_DIV;
                else
                    n_state = paeu_pkg::S_OUT;
            end
            paeu_pkg::S_DIV:   if (r_cnt == 6'd32) n_state = paeu_pkg::S_OUT;
            paeu_pkg::S_OUT:   if (m_axis_tready) n_state = paeu_pkg::S_IDLE;
            default:           n_state = paeu_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= paeu_pkg::S_CLEAR;
            r_clr    <= '0;
            r_status <= paeu_pkg::ST_ZERO;
            for (int i = 0; i < 16; i++) r_regs[i] <= 32'd0;
        end else begin
            r_state <= n_state;
            case (r_state)
                paeu_pkg::S_CLEAR: r_clr <= r_clr + 1'b1;
                paeu_pkg::S_IDLE: begin
                    r_func <= s_axis_tdata[4:0];
                    r_d    <= s_axis_tdata[8:5];
                    r_s    <= s_axis_tdata[12:9];
                    r_x    <= s_axis_tdata[16:13];
                    r_word <= s_axis_tdata[24:17];
                    r_lab  <= s_axis_tdata[25];
                    r_tgt  <= s_axis_tdata[37:26];
                    r_pc   <= s_axis_tdata[49:38];
                    r_dz   <= 1'b0;
                end
                paeu_pkg::S_EXEC: begin
                    r_npc <= w_npc;
                    case (r_func)
                        paeu_pkg::F_AR, paeu_pkg::F_A, paeu_pkg::F_SR, paeu_pkg::F_S: begin
                            r_regs[r_d] <= w_sum;
                            r_status    <= paeu_pkg::sign_status(w_sum);
                        end
                        paeu_pkg::F_MR, paeu_pkg::F_M: begin
                            r_regs[r_d] <= w_mul;
                            r_status    <= paeu_pkg::sign_status(w_mul);
                        end
                        paeu_pkg::F_DR, paeu_pkg::F_D: begin
                            r_dz   <= (w_b == 32'd0);
                            r_q    <= w_a[31] ? -w_a : w_a;
                            r_dvs  <= w_b[31] ? -w_b : w_b;
                            r_rem  <= 32'd0;
                            r_cnt  <= 6'd0;
                            r_qneg <= w_a[31] ^ w_b[31];
                        end
                        paeu_pkg::F_CR, paeu_pkg::F_C: r_status <= paeu_pkg::sign_status(w_sum);
                        paeu_pkg::F_LR, paeu_pkg::F_L: r_regs[r_d] <= w_b;
                        paeu_pkg::F_LA: if (r_lab)
                            r_regs[r_d] <= {22'd0, r_word, 2'b00} + r_regs[14]
                                + ((r_x != 4'd0) ? r_regs[r_x] : 32'd0);
                        default: ;
                    endcase
                end
                paeu_pkg::S_DIV: begin
                    if (r_cnt == 6'd32) begin
                        r_regs[r_d] <= w_res;
                        r_status    <= paeu_pkg::sign_status(w_res);
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        if (!w_trial[32]) begin
                            r_rem <= w_trial[31:0];
                            r_q   <= {r_q[30:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[30:0], r_q[31]};
                            r_q   <= {r_q[30:0], 1'b0};
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // memory address: word + r[x]/4 (if x != 0) + r14/4 (if from_label), wrapped to the memory size
    logic [31:0] w_ea;
    assign w_ea = {24'd0, r_word}
        + ((r_x != 4'd0) ? paeu_pkg::quarter(r_regs[r_x]) : 32'd0)
        + (r_lab ? paeu_pkg::quarter(r_regs[14]) : 32'd0);

    always_ff @(posedge i_clk) begin
        if (r_state == paeu_pkg::S_ADDR) r_addr <= w_ea[paeu_pkg::MemAw-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == paeu_pkg::S_CLEAR)
            r_mem[r_clr] <= 32'd0;
        else if (r_state == paeu_pkg::S_EXEC && r_func == paeu_pkg::F_ST)
            r_mem[r_addr] <= w_a;
        r_mrd <= r_mem[r_addr];
    end

endmodule

@@ tb/tb_pseudo_assembler_execute_unit.sv @@
// Testbench for the pseudo-assembler execute unit: a directed table, a memory-fill pass, then
// random instruction streams, checked against an in-bench predictor. Depends on paeu_pkg and the RTL.
`timescale 1ns / 100ps

module tb_pseudo_assembler_execute_unit;

    typedef struct packed {
        logic [11:0] pc;
        logic [11:0] jump_target;
        logic        from_label;
        logic [7:0]  mem_word;
        logic [3:0]  index_reg;
        logic [3:0]  src_reg;
        logic [3:0]  dst_reg;
        logic [4:0]  func;
    } t_instr;

    typedef struct packed {
        logic        div_by_zero;
        logic [31:0] dst_value;
        logic [1:0]  status;
        logic [11:0] next_pc;
    } t_outcome;

    typedef struct {
        t_instr   ins;
        bit       typed;
        t_outcome want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;  // func, dst_reg, src_reg, index_reg, mem_word, from_label,
                                // jump_target, pc
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;  // next_pc, status, dst_value, div_by_zero

    pseudo_assembler_execute_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    logic [31:0] regs [16];
    logic [31:0] dmem [paeu_pkg::MemWords];
    logic [1:0]  flag;
    t_outcome    pending [$];
    t_row        rows [$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 33;
    int          recv_idle_pct = 79;
    bit          hold_off = 0;
    bit          done_sending = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] div4(logic [31:0] v);
        return $signed(v) / 4;
    endfunction

    function automatic logic [1:0] sign_of(logic [31:0] v);
        if (v == 0) return paeu_pkg::ST_ZERO;
        return v[31] ? paeu_pkg::ST_NEG : paeu_pkg::ST_POS;
    endfunction

    function automatic t_outcome execute(t_instr ins);
        t_outcome    o;
        logic [31:0] a, b, addr_sum, v;
        logic [paeu_pkg::MemAw-1:0] addr;
        logic [11:0] nxt;
        bit          dz;
        a = regs[ins.dst_reg];
        dz = 0;
        nxt = ins.pc + 12'd1;
        addr_sum = {24'd0, ins.mem_word};
        if (ins.index_reg != 0) addr_sum += div4(regs[ins.index_reg]);
        if (ins.from_label) addr_sum += div4(regs[14]);
        addr = addr_sum[paeu_pkg::MemAw-1:0];
        b = (ins.func <= paeu_pkg::F_LR) ? regs[ins.src_reg] : dmem[addr];
        case (ins.func)
            paeu_pkg::F_AR, paeu_pkg::F_A: begin
                a = a + b; regs[ins.dst_reg] = a; flag = sign_of(a);
            end
            paeu_pkg::F_SR, paeu_pkg::F_S: begin
                a = a - b; regs[ins.dst_reg] = a; flag = sign_of(a);
            end
            paeu_pkg::F_MR, paeu_pkg::F_M: begin
                a = a * b; regs[ins.dst_reg] = a; flag = sign_of(a);
            end
            paeu_pkg::F_DR, paeu_pkg::F_D: begin
                if (b == 0) dz = 1;
                else begin
                    if (a == 32'h8000_0000 && b == 32'hffff_ffff) a = 32'h8000_0000;
                    else a = $signed(a) / $signed(b);
                    regs[ins.dst_reg] = a;
                    flag = sign_of(a);
                end
            end
            paeu_pkg::F_CR, paeu_pkg::F_C: flag = sign_of(a - b);
            paeu_pkg::F_LR, paeu_pkg::F_L: regs[ins.dst_reg] = b;
            paeu_pkg::F_LA: begin
                if (ins.from_label) begin
                    v = {22'd0, ins.mem_word, 2'b00} + regs[14];
                    if (ins.index_reg != 0) v += regs[ins.index_reg];
                    regs[ins.dst_reg] = v;
                end
            end
            paeu_pkg::F_ST: dmem[addr] = a;
            paeu_pkg::F_J, paeu_pkg::F_JP, paeu_pkg::F_JN, paeu_pkg::F_JZ: begin
                if (ins.func == paeu_pkg::F_J ||
                    (ins.func == paeu_pkg::F_JP && flag == paeu_pkg::ST_POS) ||
                    (ins.func == paeu_pkg::F_JN && flag == paeu_pkg::ST_NEG) ||
                    (ins.func == paeu_pkg::F_JZ && flag == paeu_pkg::ST_ZERO))
                    nxt = 12'(ins.jump_target + div4(regs[15]));
            end
            default: ;
        endcase
        o.next_pc = nxt;
        o.status = flag;
        o.dst_value = regs[ins.dst_reg];
        o.div_by_zero = dz;
        return o;
    endfunction

    function automatic t_instr mk(logic [4:0] f, logic [3:0] d, logic [3:0] s, logic [3:0] x,
                                  logic [7:0] w, logic l, logic [11:0] t, logic [11:0] p);
        t_instr i;
        i = '{pc: p, jump_target: t, from_label: l, mem_word: w, index_reg: x,
              src_reg: s, dst_reg: d, func: f};
        return i;
    endfunction

    function automatic t_instr rnd_instr();
        t_instr i;
        i = 50'({$urandom, $urandom});
        i.func = $urandom_range(0, 40) == 0 ? 5'($urandom_range(18, 31))
                                             : 5'($urandom_range(0, 17));
        if ($urandom_range(0, 2) == 0) i.index_reg = 0;
        return i;
    endfunction

    // directed table: typed rows are trivially known, the rest use the predictor
    initial begin
        t_row r;
        r.typed = 0;
        r.want = '0;
        r.ins = mk(paeu_pkg::F_AR, 4'd3, 4'd4, 0, 0, 0, 0, 12'd0);
        r.typed = 1;
        r.want = '{div_by_zero: 0, dst_value: 0, status: paeu_pkg::ST_ZERO, next_pc: 1};
        rows.push_back(r);
        r.ins = mk(paeu_pkg::F_DR, 4'd1, 4'd2, 0, 0, 0, 0, 12'hfff);
        r.want = '{div_by_zero: 1, dst_value: 0, status: paeu_pkg::ST_ZERO, next_pc: 0};
        rows.push_back(r);
        r.ins = mk(paeu_pkg::F_D, 4'd15, 0, 4'd15, 8'hff, 1, 12'hfff, 12'd7);
        r.want = '{div_by_zero: 1, dst_value: 0, status: paeu_pkg::ST_ZERO, next_pc: 8};
        rows.push_back(r);
        r.ins = mk(paeu_pkg::F_J, 0, 0, 0, 0, 0, 12'hfff, 12'd5);
        r.want = '{div_by_zero: 0, dst_value: 0, status: paeu_pkg::ST_ZERO, next_pc: 12'hfff};
        rows.push_back(r);
        r.typed = 0;
        r.ins = mk(paeu_pkg::F_LA, 4'd1, 0, 0, 8'hff, 1, 0, 12'd1);        rows.push_back(r);
        r.ins = mk(paeu_pkg::F_LA, 4'd2, 0, 0, 8'h10, 0, 0, 12'd2);        rows.push_back(r);
        r.ins = mk(paeu_pkg::F_ST, 4'd1, 0, 0, 8'h20, 0, 0, 12'd3);        rows.push_back(r);
        r.ins = mk(paeu_pkg::F_L, 4'd14, 0, 0, 8'h20, 0, 0, 12'd4);        rows.push_back(r);
        r.ins = mk(paeu_pkg::F_LA, 4'd15, 0, 4'd14, 8'h03, 1, 0, 12'd5);   rows.push_back(r);
        r.ins = mk(paeu_pkg::F_A, 4'd5, 0, 4'd1, 8'h01, 1, 0, 12'd6);      rows.push_back(r);
        r.ins = mk(paeu_pkg::F_SR, 4'd6, 4'd1, 0, 0, 0, 0, 12'd7);         rows.push_back(r);
        r.ins = mk(paeu_pkg::F_MR, 4'd6, 4'd6, 0, 0, 0, 0, 12'd8);         rows.push_back(r);
        r.ins = mk(paeu_pkg::F_CR, 4'd6, 4'd1, 0, 0, 0, 0, 12'd9);         rows.push_back(r);
        r.ins = mk(paeu_pkg::F_JN, 0, 0, 0, 0, 0, 12'd100, 12'd10);        rows.push_back(r);
        r.ins = mk(paeu_pkg::F_JP, 0, 0, 0, 0, 0, 12'd100, 12'd11);        rows.push_back(r);
        r.ins = mk(paeu_pkg::F_JZ, 0, 0, 0, 0, 0, 12'd100, 12'd12);        rows.push_back(r);
        r.ins = mk(paeu_pkg::F_S, 4'd7, 0, 0, 8'h33, 0, 0, 12'd13);        rows.push_back(r);
        r.ins = mk(paeu_pkg::F_M, 4'd7, 0, 0, 8'h20, 0, 0, 12'd14);        rows.push_back(r);
        r.ins = mk(paeu_pkg::F_C, 4'd7, 0, 0, 8'h20, 0, 0, 12'd15);        rows.push_back(r);
        r.ins = mk(paeu_pkg::F_LR, 4'd8, 4'd7, 0, 0, 0, 0, 12'd16);        rows.push_back(r);
        r.ins = mk(paeu_pkg::F_DR, 4'd8, 4'd1, 0, 0, 0, 0, 12'd17);        rows.push_back(r);
        r.ins = mk(paeu_pkg::F_D, 4'd8, 0, 0, 8'h20, 0, 0, 12'd18);        rows.push_back(r);
        r.ins = mk(5'd31, 4'd8, 0, 0, 0, 0, 0, 12'hffe);                   rows.push_back(r);
        r.ins = mk(paeu_pkg::F_J, 0, 0, 0, 0, 0, 12'hffe, 12'd19);         rows.push_back(r);
    end

    task automatic send(t_instr ins, bit typed, t_outcome want);
        t_outcome o;
        while ($urandom_range(1, 100) <= send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, ins};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        o = execute(ins);
        pending.push_back(typed ? want : o);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic random_phase(int n);
        t_instr ins;
        for (int k = 0; k < n; k++) begin
            // seed a random register often with a load address so operands reach extremes
            if ($urandom_range(0, 3) == 0) begin
                ins = mk(paeu_pkg::F_LA, 4'($urandom), 0, 0, 8'($urandom), 1, 0,
                         12'($urandom));
                send(ins, 0, '0);
                ins = mk(paeu_pkg::F_A, ins.dst_reg, 0, 0, 8'($urandom), 0, 0, 12'($urandom));
                dmem[0] = dmem[0];
            end
            ins = rnd_instr();
            if ($urandom_range(0, 5) == 0) begin
                ins.func = paeu_pkg::F_ST;
                ins.dst_reg = 4'($urandom);
            end
            if ($urandom_range(0, 7) == 0) begin
                ins.func = paeu_pkg::F_LR;
                ins.src_reg = 0;
                regs[0] = regs[0];
            end
            send(ins, 0, '0);
            if ($urandom_range(0, 9) == 0) begin
                // load an edge value into a register through memory
                ins = mk(paeu_pkg::F_L, 4'($urandom), 0, 0, 8'($urandom), 0, 0, 12'($urandom));
                send(ins, 0, '0);
            end
        end
    endtask

    initial begin
        t_instr ins;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        foreach (regs[k]) regs[k] = '0;
        foreach (dmem[k]) dmem[k] = '0;
        flag = paeu_pkg::ST_ZERO;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[k]) send(rows[k].ins, rows[k].typed, rows[k].want);
        // fill memory with edge values via stores of loaded-address registers multiplied by other registers
        for (int k = 0; k < 24; k++) begin
            ins = mk(paeu_pkg::F_LA, 4'd9, 0, 0, 8'($urandom), 1, 0, 12'($urandom));
            send(ins, 0, '0);
            ins = mk(paeu_pkg::F_MR, 4'd9, 4'(k % 16), 0, 0, 0, 0, 12'($urandom));
            send(ins, 0, '0);
            ins = mk(paeu_pkg::F_ST, 4'd9, 0, 4'($urandom), 8'($urandom), 1'($urandom), 0,
                     12'($urandom));
            send(ins, 0, '0);
        end
        hold_off = 1;
        random_phase(20);
        random_phase(90);
        drain();
        send_idle_pct = 79;
        recv_idle_pct = 33;
        random_phase(110);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(115);
        s_axis_tvalid <= 1'b0;
        done_sending = 1;
    end

    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                hold_off = 0;
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end
            m_axis_tready <= ($urandom_range(1, 100) > recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_outcome got, exp_o;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[46:0];
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_o = pending.pop_front();
                if (got.next_pc !== exp_o.next_pc) begin
                    $display("%0t: next_pc exp %h got %h", $time, exp_o.next_pc, got.next_pc);
                    errors++;
                end
                if (got.status !== exp_o.status) begin
                    $display("%0t: status exp %h got %h", $time, exp_o.status, got.status);
                    errors++;
                end
                if (got.dst_value !== exp_o.dst_value) begin
                    $display("%0t: dst_value exp %h got %h", $time, exp_o.dst_value,
                             got.dst_value);
                    errors++;
                end
                if (got.div_by_zero !== exp_o.div_by_zero) begin
                    $display("%0t: div_by_zero exp %b got %b", $time, exp_o.div_by_zero,
                             got.div_by_zero);
                    errors++;
                end
            end
        end
    end

    initial begin
        bit timed_out;
        timed_out = 0;
        while (!(done_sending && pending.size() == 0) && !timed_out) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 5000) timed_out = 1;
        end
        if (!timed_out) repeat (40) @(posedge i_clk);
        if (!timed_out && errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ pseudo_assembler_execute_unit.f @@
hdl/paeu_pkg.sv
hdl/pseudo_assembler_execute_unit.sv
tb/tb_pseudo_assembler_execute_unit.sv
